// ===== sv/vpcd_pkg.sv =====
package vpcd_pkg;

	localparam logic [7:0] BYTE_END  = 8'hFF;
	localparam logic [7:0] BYTE_ABS  = 8'hF6;
	localparam logic [7:0] BYTE_REL  = 8'hF7;
	localparam logic [7:0] BYTE_PLOT = 8'hFA;
	localparam logic [7:0] BYTE_FILL = 8'hF8;

	localparam logic [2:0] CLS_ARG  = 3'd0;
	localparam logic [2:0] CLS_END  = 3'd1;
	localparam logic [2:0] CLS_ABS  = 3'd2;
	localparam logic [2:0] CLS_REL  = 3'd3;
	localparam logic [2:0] CLS_PLOT = 3'd4;
	localparam logic [2:0] CLS_FILL = 3'd5;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_ABS  = 3'd1;
	localparam logic [2:0] CMD_REL  = 3'd2;
	localparam logic [2:0] CMD_PLOT = 3'd3;
	localparam logic [2:0] CMD_FILL = 3'd4;

	localparam logic [1:0] KIND_LINE = 2'd0;
	localparam logic [1:0] KIND_PLOT = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] data;
	} vpcd_beat_t;

endpackage

// ===== sv/vpcd_front.sv =====
module vpcd_front import vpcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       stream_valid,
	output logic       stream_stall,
	input  logic [7:0] stream_byte,
	output logic       push,
	output vpcd_beat_t beat,
	input  logic       queue_full
);

	logic       valid_s1;
	vpcd_beat_t beat_s1;
	vpcd_beat_t beat_c;
	logic       accept;

	always_comb begin
		beat_c.data = stream_byte;
		case (stream_byte)
			BYTE_END:  beat_c.cls = CLS_END;
			BYTE_ABS:  beat_c.cls = CLS_ABS;
			BYTE_REL:  beat_c.cls = CLS_REL;
			BYTE_PLOT: beat_c.cls = CLS_PLOT;
			BYTE_FILL: beat_c.cls = CLS_FILL;
			default:   beat_c.cls = CLS_ARG;
		endcase
	end

	assign stream_stall = valid_s1 && queue_full;
	assign accept       = stream_valid && !stream_stall;
	assign push         = valid_s1 && !queue_full;
	assign beat         = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= beat_c;
		end
	end

endmodule

// ===== sv/vpcd_queue.sv =====
module vpcd_queue import vpcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vpcd_beat_t wr_beat,
	output logic       full,
	input  logic       pop,
	output vpcd_beat_t rd_beat,
	output logic       empty
);

	vpcd_beat_t          mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_beat = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/vpcd_back.sv =====
module vpcd_back import vpcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  vpcd_beat_t head,
	input  logic       head_valid,
	output logic       pop,
	output logic       draw_valid,
	input  logic       draw_stall,
	output logic [1:0] draw_kind,
	output logic [7:0] start_x,
	output logic [7:0] start_y,
	output logic [7:0] end_x,
	output logic [7:0] end_y
);

	logic [2:0] cmd_q, cmd_d;
	logic [2:0] need_q, need_d;
	logic [2:0] recv_q, recv_d;
	logic [1:0] fill_q, fill_d;
	logic [1:0] fill_p1;
	logic [7:0] store_q [4];
	logic [7:0] store_d [4];
	logic [7:0] pen_x_q, pen_x_d;
	logic [7:0] pen_y_q, pen_y_d;
	logic       emit;
	logic [1:0] kind_d;
	logic [7:0] sx_d, sy_d, ex_d, ey_d;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] sx_q, sy_q, ex_q, ey_q;

	function automatic logic [7:0] apply_offset(input logic [7:0] base, input logic [3:0] nib);
		if (nib[3]) begin
			return base - {5'd0, nib[2:0]};
		end
		return base + {5'd0, nib[2:0]};
	endfunction

	assign pop = head_valid && (!valid_q || !draw_stall);

	always_comb begin
		cmd_d   = cmd_q;
		need_d  = need_q;
		recv_d  = recv_q;
		fill_d  = fill_q;
		fill_p1 = fill_q + 2'd1;
		store_d = store_q;
		pen_x_d = pen_x_q;
		pen_y_d = pen_y_q;
		emit    = 1'b0;
		kind_d  = KIND_END;
		sx_d    = 8'd0;
		sy_d    = 8'd0;
		ex_d    = 8'd0;
		ey_d    = 8'd0;
		if (pop) begin
			if (head.cls == CLS_END) begin
				cmd_d   = CMD_NONE;
				need_d  = 3'd0;
				recv_d  = 3'd0;
				fill_d  = 2'd0;
				store_d = '{default: 8'd0};
				pen_x_d = 8'd0;
				pen_y_d = 8'd0;
				emit    = 1'b1;
			end else if (recv_q == 3'd0 && head.cls != CLS_ARG) begin
				case (head.cls)
					CLS_ABS: begin
						pen_x_d = 8'd0;
						pen_y_d = 8'd0;
						cmd_d   = CMD_ABS;
						need_d  = 3'd4;
						fill_d  = 2'd0;
					end
					CLS_PLOT: begin
						pen_x_d = 8'd0;
						pen_y_d = 8'd0;
						cmd_d   = CMD_PLOT;
						need_d  = 3'd2;
						fill_d  = 2'd0;
					end
					CLS_FILL: begin
						pen_x_d = 8'd0;
						pen_y_d = 8'd0;
						cmd_d   = CMD_FILL;
						need_d  = 3'd3;
						fill_d  = 2'd0;
					end
					CLS_REL: begin
						cmd_d      = CMD_REL;
						need_d     = 3'd1;
						store_d[0] = pen_y_q;
						store_d[1] = pen_x_q;
						fill_d     = 2'd2;
					end
					default: begin
					end
				endcase
			end else if (recv_q < need_q) begin
				if (cmd_q == CMD_REL) begin
					store_d[fill_q]  = apply_offset(pen_y_q, head.data[3:0]);
					store_d[fill_p1] = apply_offset(pen_x_q, head.data[7:4]);
					fill_d           = fill_q + 2'd2;
					recv_d           = recv_q + 3'd2;
				end else begin
					store_d[fill_q] = head.data;
					fill_d          = fill_p1;
					recv_d          = recv_q + 3'd1;
				end
				if (recv_d >= need_q) begin
					case (cmd_q)
						CMD_ABS, CMD_REL: begin
							emit       = 1'b1;
							kind_d     = KIND_LINE;
							sx_d       = store_d[1];
							sy_d       = store_d[0];
							ex_d       = store_d[3];
							ey_d       = store_d[2];
							pen_x_d    = store_d[3];
							pen_y_d    = store_d[2];
							store_d[0] = store_d[2];
							store_d[1] = store_d[3];
							fill_d     = 2'd2;
							need_d     = 3'd2;
							recv_d     = 3'd0;
						end
						CMD_PLOT, CMD_FILL: begin
							emit    = 1'b1;
							kind_d  = (cmd_q == CMD_PLOT) ? KIND_PLOT : KIND_FILL;
							sx_d    = store_d[1];
							sy_d    = store_d[0];
							pen_x_d = store_d[1];
							pen_y_d = store_d[0];
							fill_d  = 2'd0;
							recv_d  = 3'd0;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_NONE;
			need_q  <= 3'd0;
			recv_q  <= 3'd0;
			fill_q  <= 2'd0;
			store_q <= '{default: 8'd0};
			pen_x_q <= 8'd0;
			pen_y_q <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			cmd_q   <= cmd_d;
			need_q  <= need_d;
			recv_q  <= recv_d;
			fill_q  <= fill_d;
			store_q <= store_d;
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			if (pop) begin
				valid_q <= emit;
			end else if (!draw_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q <= kind_d;
			sx_q   <= sx_d;
			sy_q   <= sy_d;
			ex_q   <= ex_d;
			ey_q   <= ey_d;
		end
	end

	assign draw_valid = valid_q;
	assign draw_kind  = kind_q;
	assign start_x    = sx_q;
	assign start_y    = sy_q;
	assign end_x      = ex_q;
	assign end_y      = ey_q;

endmodule

// ===== sv/vector_picture_command_decoder.sv =====
// A result passes through the front register, a queue entry and the output register before it is presented.
// Throughput: one byte per cycle while stream_stall is low; a four-beat queue separates byte decode from execution,
// so either side may stall without holding up the other until the queue fills.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and returns the decoder
// to the start of a picture: no command active, pen at the origin.
module vector_picture_command_decoder import vpcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       stream_valid,
	output logic       stream_stall,
	input  logic [7:0] stream_byte,
	output logic       draw_valid,
	input  logic       draw_stall,
	output logic [1:0] draw_kind,
	output logic [7:0] start_x,
	output logic [7:0] start_y,
	output logic [7:0] end_x,
	output logic [7:0] end_y
);

	logic       push;
	vpcd_beat_t wr_beat;
	logic       queue_full;
	logic       pop;
	vpcd_beat_t rd_beat;
	logic       queue_empty;

	vpcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_byte  (stream_byte),
		.push         (push),
		.beat         (wr_beat),
		.queue_full   (queue_full)
	);

	vpcd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_beat (wr_beat),
		.full    (queue_full),
		.pop     (pop),
		.rd_beat (rd_beat),
		.empty   (queue_empty)
	);

	vpcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_beat),
		.head_valid (!queue_empty),
		.pop        (pop),
		.draw_valid (draw_valid),
		.draw_stall (draw_stall),
		.draw_kind  (draw_kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y)
	);

endmodule

// ===== sim/tb_vector_picture_command_decoder.sv =====
module tb_vector_picture_command_decoder import vpcd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_BYTES = 840;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] sx;
		logic [7:0] sy;
		logic [7:0] ex;
		logic [7:0] ey;
	} draw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       stream_valid = 1'b0;
	logic       stream_stall;
	logic [7:0] stream_byte = '0;
	logic       draw_valid;
	logic       draw_stall = 1'b0;
	logic [1:0] draw_kind;
	logic [7:0] start_x;
	logic [7:0] start_y;
	logic [7:0] end_x;
	logic [7:0] end_y;

	logic [2:0] pic_cmd;
	logic [2:0] args_needed;
	logic [2:0] args_got;
	logic [2:0] arg_slot;
	logic [7:0] arg_buf [4];
	logic [7:0] pen_x;
	logic [7:0] pen_y;

	draw_t expected_draws [$];
	int    mismatches = 0;
	int    bytes_sent = 0;
	int    idle_cycles = 0;
	bit    feed_gaps_on = 1'b1;
	bit    sink_gaps_on = 1'b1;
	bit    sink_hold_req = 1'b0;

	logic [7:0] command_bytes [4] = '{BYTE_ABS, BYTE_REL, BYTE_PLOT, BYTE_FILL};

	vector_picture_command_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream_valid(stream_valid),
		.stream_stall(stream_stall),
		.stream_byte(stream_byte),
		.draw_valid(draw_valid),
		.draw_stall(draw_stall),
		.draw_kind(draw_kind),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y)
	);

	always #6 clk = ~clk;

	function automatic void clear_picture();
		pic_cmd = CMD_NONE;
		args_needed = '0;
		args_got = '0;
		arg_slot = '0;
		foreach (arg_buf[i]) arg_buf[i] = '0;
		pen_x = '0;
		pen_y = '0;
	endfunction

	function automatic void put_arg(input logic [7:0] v);
		arg_buf[arg_slot[1:0]] = v;
		arg_slot = arg_slot + 3'd1;
	endfunction

	// Sign-magnitude nibble: bit 3 selects subtraction of bits 2..0.
	function automatic logic [7:0] offset_coord(input logic [7:0] base, input logic [3:0] nib);
		return nib[3] ? base - {5'd0, nib[2:0]} : base + {5'd0, nib[2:0]};
	endfunction

	function automatic bit predict_draw(input logic [7:0] b, output draw_t d);
		d = '0;
		if (b == BYTE_END) begin
			clear_picture();
			d.kind = KIND_END;
			return 1'b1;
		end
		if (b > 8'hF0 && args_got == 3'd0) begin
			if (b == BYTE_ABS || b == BYTE_PLOT || b == BYTE_FILL) begin
				pen_x = '0;
				pen_y = '0;
				if (b == BYTE_ABS) begin
					pic_cmd = CMD_ABS;
					args_needed = 3'd4;
				end else if (b == BYTE_PLOT) begin
					pic_cmd = CMD_PLOT;
					args_needed = 3'd2;
				end else begin
					pic_cmd = CMD_FILL;
					args_needed = 3'd3;
				end
				arg_slot = '0;
				return 1'b0;
			end
			if (b == BYTE_REL) begin
				pic_cmd = CMD_REL;
				args_needed = 3'd1;
				arg_buf[0] = pen_y;
				arg_buf[1] = pen_x;
				arg_slot = 3'd2;
				return 1'b0;
			end
		end
		if (args_got >= args_needed)
			return 1'b0;
		if (pic_cmd == CMD_REL) begin
			put_arg(offset_coord(pen_y, b[3:0]));
			put_arg(offset_coord(pen_x, b[7:4]));
			args_got = args_got + 3'd2;
		end else begin
			put_arg(b);
			args_got = args_got + 3'd1;
		end
		if (args_got < args_needed)
			return 1'b0;
		if (pic_cmd == CMD_ABS || pic_cmd == CMD_REL) begin
			d.kind = KIND_LINE;
			d.sx = arg_buf[1];
			d.sy = arg_buf[0];
			d.ex = arg_buf[3];
			d.ey = arg_buf[2];
			pen_x = arg_buf[3];
			pen_y = arg_buf[2];
			arg_buf[0] = pen_y;
			arg_buf[1] = pen_x;
			arg_slot = 3'd2;
			args_needed = 3'd2;
			args_got = '0;
			return 1'b1;
		end
		if (pic_cmd == CMD_PLOT || pic_cmd == CMD_FILL) begin
			pen_x = arg_buf[1];
			pen_y = arg_buf[0];
			d.kind = (pic_cmd == CMD_PLOT) ? KIND_PLOT : KIND_FILL;
			d.sx = pen_x;
			d.sy = pen_y;
			arg_slot = '0;
			args_got = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] random_arg();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(8'hF0, 8'hFE));
		return 8'($urandom_range(0, 254));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		draw_t d;
		int gap;
		gap = (feed_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			stream_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (stream_stall) @(posedge clk);
		bytes_sent++;
		if (predict_draw(b, d))
			expected_draws.push_back(d);
	endtask

	task automatic send_list(input logic [7:0] bytes [$]);
		foreach (bytes[i]) send_byte(bytes[i]);
	endtask

	task automatic test_idle_bytes();
		send_list('{8'h00, 8'hF0, 8'hF3, 8'hFE, BYTE_END});
	endtask

	task automatic test_absolute_lines();
		// A command byte arriving after the first argument is taken as a coordinate.
		send_list('{BYTE_ABS, 8'h00, BYTE_ABS, 8'hFE, 8'h80, 8'h7F, 8'hF1, 8'h3C});
	endtask

	task automatic test_relative_lines();
		send_list('{BYTE_REL, 8'h00, 8'h88, 8'h7F, 8'hF0, 8'hF3});
	endtask

	task automatic test_plot_and_fill();
		// The picture is ended while a fill still waits for its second argument.
		send_list('{BYTE_PLOT, 8'h10, BYTE_PLOT, BYTE_FILL, 8'h20, 8'h30, 8'h5A,
			8'h40, BYTE_END});
	endtask

	task automatic test_output_backpressure();
		feed_gaps_on = 1'b0;
		sink_hold_req = 1'b1;
		wait (sink_hold_req == 1'b0);
		send_byte(BYTE_PLOT);
		repeat (30) send_byte(8'($urandom_range(0, 239)));
		feed_gaps_on = 1'b1;
	endtask

	task automatic test_random_pictures();
		int first;
		int pick;
		int n;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			if ($urandom_range(0, 11) == 0) begin
				feed_gaps_on = $urandom_range(0, 2) != 0;
				sink_gaps_on = $urandom_range(0, 2) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_byte(BYTE_ABS);
				repeat (4 + 2 * $urandom_range(0, 4)) send_byte(random_arg());
			end else if (pick < 55) begin
				send_byte(BYTE_REL);
				repeat ($urandom_range(1, 8)) send_byte(random_arg());
			end else if (pick < 70) begin
				send_byte(BYTE_PLOT);
				repeat (2 * $urandom_range(1, 3)) send_byte(random_arg());
			end else if (pick < 85) begin
				send_byte(BYTE_FILL);
				repeat (3 * $urandom_range(1, 2)) send_byte(random_arg());
			end else if (pick < 90) begin
				send_byte(BYTE_END);
			end else if (pick < 95) begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte(command_bytes[$urandom_range(0, 3)]);
				send_byte(random_arg());
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		draw_t want;
		if (arst_n && draw_valid && !draw_stall) begin
			if (expected_draws.size() == 0) begin
				$display("%0t: unexpected draw beat, expected none got kind %0d (%0h,%0h)-(%0h,%0h)",
					$time, draw_kind, start_x, start_y, end_x, end_y);
				mismatches++;
			end else begin
				want = expected_draws.pop_front();
				check_field("draw_kind", {6'd0, want.kind}, {6'd0, draw_kind});
				check_field("start_x", want.sx, start_x);
				check_field("start_y", want.sy, start_y);
				check_field("end_x", want.ex, end_x);
				check_field("end_y", want.ey, end_y);
			end
		end
	end

	always @(posedge clk) begin
		if ((stream_valid && !stream_stall) || (draw_valid && !draw_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STUCK_LIMIT) begin
			$display("vector_picture_command_decoder test failed");
			$finish;
		end
	end

	initial begin : draw_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				draw_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
				draw_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
			end
			draw_stall <= 1'b0;
		end
	end

	initial begin
		clear_picture();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_absolute_lines();
		test_relative_lines();
		test_plot_and_fill();
		test_output_backpressure();
		test_random_pictures();
		stream_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("vector_picture_command_decoder test passed");
		else
			$display("vector_picture_command_decoder test failed");
		$finish;
	end

endmodule
